// ----- rtl/core/audio_volume_ramp_scope_path_assert.svh -----
// Assertion macros shared by the volume path checker.
// Needs nothing else; included by the checker file only.
`ifndef AUDIO_VOLUME_RAMP_SCOPE_PATH_ASSERT_SVH
`define AUDIO_VOLUME_RAMP_SCOPE_PATH_ASSERT_SVH

// same-cycle implication, masked during reset
`define AVRSP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("avrsp assertion failed");

// next-cycle implication, masked during reset
`define AVRSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("avrsp assertion failed");

// next-cycle implication that is also checked across reset
`define AVRSP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("avrsp assertion failed");

`endif

// ----- rtl/core/avrsp_pkg.sv -----
// Shared types, constants and the gain table of the volume path.
// No dependencies.
`default_nettype none

package avrsp_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 17;
   localparam int VOL_W       = 6;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [VOL_W-1:0]  MAX_STEP   = 6'd60;
   localparam logic [VOL_W-1:0]  RESET_STEP = 6'd45;
   localparam logic [GAIN_W-1:0] DECAY_Q15  = 17'd27853;
   localparam logic [GAIN_W-1:0] SNAP_LIMIT = 17'd4;

   typedef enum logic {
      CSR_VOLUME_STEP  = 1'b0,
      CSR_SCOPE_ENABLE = 1'b1
   } avrsp_csr_type;

   // per-word control carried from front to back
   typedef struct packed {
      logic idle;
      logic scope_valid;
   } avrsp_ctl_type;

   // Q16 gains, step 0 is mute, 60 is unity
   function automatic logic [GAIN_W-1:0] gain_q16(input logic [VOL_W-1:0] step);
      logic [GAIN_W-1:0] g;
      case (step)
         6'd0:  g = 17'd0;      6'd1:  g = 17'd74;     6'd2:  g = 17'd83;
         6'd3:  g = 17'd93;     6'd4:  g = 17'd104;    6'd5:  g = 17'd117;
         6'd6:  g = 17'd131;    6'd7:  g = 17'd147;    6'd8:  g = 17'd165;
         6'd9:  g = 17'd185;    6'd10: g = 17'd207;    6'd11: g = 17'd233;
         6'd12: g = 17'd261;    6'd13: g = 17'd293;    6'd14: g = 17'd328;
         6'd15: g = 17'd369;    6'd16: g = 17'd414;    6'd17: g = 17'd464;
         6'd18: g = 17'd521;    6'd19: g = 17'd584;    6'd20: g = 17'd655;
         6'd21: g = 17'd735;    6'd22: g = 17'd825;    6'd23: g = 17'd926;
         6'd24: g = 17'd1039;   6'd25: g = 17'd1165;   6'd26: g = 17'd1308;
         6'd27: g = 17'd1467;   6'd28: g = 17'd1646;   6'd29: g = 17'd1847;
         6'd30: g = 17'd2072;   6'd31: g = 17'd2325;   6'd32: g = 17'd2609;
         6'd33: g = 17'd2927;   6'd34: g = 17'd3285;   6'd35: g = 17'd3685;
         6'd36: g = 17'd4135;   6'd37: g = 17'd4640;   6'd38: g = 17'd5206;
         6'd39: g = 17'd5841;   6'd40: g = 17'd6554;   6'd41: g = 17'd7353;
         6'd42: g = 17'd8251;   6'd43: g = 17'd9257;   6'd44: g = 17'd10387;
         6'd45: g = 17'd11654;  6'd46: g = 17'd13076;  6'd47: g = 17'd14672;
         6'd48: g = 17'd16462;  6'd49: g = 17'd18471;  6'd50: g = 17'd20724;
         6'd51: g = 17'd23253;  6'd52: g = 17'd26090;  6'd53: g = 17'd29274;
         6'd54: g = 17'd32846;  6'd55: g = 17'd36854;  6'd56: g = 17'd41350;
         6'd57: g = 17'd46396;  6'd58: g = 17'd52057;  6'd59: g = 17'd58409;
         default: g = 17'd65536;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/avrsp_front.sv -----
// Front end: accepts words, classifies sample vs idle, keeps the scope sums.
// Uses avrsp_pkg; pushes one entry per word into avrsp_queue.
`default_nettype none

module avrsp_front #(
   parameter int DECIM = 20,
   parameter int SUM_W = 22
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic signed [15:0]            req_left_in,
   input  wire logic signed [15:0]            req_right_in,
   input  wire logic                          scope_enable,
   input  wire logic                          queue_full,
   output logic                               push,
   output avrsp_pkg::avrsp_ctl_type           push_ctl,
   output logic signed [15:0]                 push_left,
   output logic signed [15:0]                 push_right,
   output logic signed [SUM_W-1:0]            push_sum_left,
   output logic signed [SUM_W-1:0]            push_sum_right
);
   import avrsp_pkg::*;

   localparam int CNT_W = (DECIM > 1) ? $clog2(DECIM) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DECIM - 1);

   logic signed [SUM_W-1:0] sum_left_ff, sum_left_in;
   logic signed [SUM_W-1:0] sum_right_ff, sum_right_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] total_left, total_right;
   logic                    summing, emit;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign summing = push && !req_action && scope_enable;
   assign emit    = summing && (cnt_ff == LAST_CNT);

   assign total_left  = sum_left_ff  + {{(SUM_W-SAMPLE_W){req_left_in[15]}},  req_left_in};
   assign total_right = sum_right_ff + {{(SUM_W-SAMPLE_W){req_right_in[15]}}, req_right_in};

   always_comb begin
      sum_left_in  = sum_left_ff;
      sum_right_in = sum_right_ff;
      cnt_in       = cnt_ff;
      if (emit) begin
         sum_left_in  = '0;
         sum_right_in = '0;
         cnt_in       = '0;
      end else if (summing) begin
         sum_left_in  = total_left;
         sum_right_in = total_right;
         cnt_in       = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_left_ff  <= '0;
         sum_right_ff <= '0;
         cnt_ff       <= '0;
      end else begin
         sum_left_ff  <= sum_left_in;
         sum_right_ff <= sum_right_in;
         cnt_ff       <= cnt_in;
      end
   end

   // sums travel only with the word that closes a window, else zero
   assign push_ctl.idle        = req_action;
   assign push_ctl.scope_valid = emit;
   assign push_left            = req_left_in;
   assign push_right           = req_right_in;
   assign push_sum_left        = emit ? total_left  : '0;
   assign push_sum_right       = emit ? total_right : '0;

endmodule

`default_nettype wire

// ----- rtl/core/avrsp_queue.sv -----
// Short FIFO between front and back of the volume path.
// Standalone; no package dependency.
`default_nettype none

module avrsp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  not_empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign rdata     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/avrsp_back.sv -----
// Back end: gain / decay multiply with the held frame, then scope average
// by reciprocal multiply. Three stages. Uses avrsp_pkg.
`default_nettype none

module avrsp_back #(
   parameter int DECIM = 20,
   parameter int SUM_W = 22
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      entry_valid,
   output logic                           pop,
   input  wire avrsp_pkg::avrsp_ctl_type  entry_ctl,
   input  wire logic signed [15:0]        entry_left,
   input  wire logic signed [15:0]        entry_right,
   input  wire logic signed [SUM_W-1:0]   entry_sum_left,
   input  wire logic signed [SUM_W-1:0]   entry_sum_right,
   input  wire logic [5:0]                volume_step,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [15:0]             rsp_left_out,
   output logic signed [15:0]             rsp_right_out,
   output logic                           rsp_scope_valid,
   output logic signed [15:0]             rsp_scope_left,
   output logic signed [15:0]             rsp_scope_right
);
   import avrsp_pkg::*;

   // floor(mag / DECIM) == (mag * RECIP) >> SHIFT for every mag < 2^SUM_W
   localparam int LOG_D  = $clog2(DECIM);
   localparam int SHIFT  = SUM_W + LOG_D;
   localparam int REC_W  = SUM_W + 2;
   localparam int PROD_W = SUM_W + REC_W;
   localparam logic [REC_W-1:0] RECIP =
      REC_W'(((64'd1 << SHIFT) + 64'(DECIM) - 64'd1) / 64'(DECIM));

   logic advance;
   logic v1_ff, v2_ff, out_v_ff;

   // stage 1
   logic signed [15:0]      held_left_ff, held_left_in;
   logic signed [15:0]      held_right_ff, held_right_in;
   logic [GAIN_W-1:0]       coef;
   logic [SUM_W-1:0]        mag_left_ff, mag_right_ff;
   logic                    neg_left_ff, neg_right_ff, sv1_ff;

   // stage 2
   logic [PROD_W-1:0]       prod_left_ff, prod_right_ff;
   logic                    neg_left2_ff, neg_right2_ff, sv2_ff;
   logic signed [15:0]      held_left2_ff, held_right2_ff;

   // output stage
   logic signed [15:0]      out_left_ff, out_right_ff, scope_left_ff, scope_right_ff;
   logic                    out_sv_ff;
   logic [16:0]             quot_left, quot_right;

   assign advance = !out_v_ff || !rsp_stall;
   assign pop     = advance && entry_valid;

   assign coef = entry_ctl.idle ? DECAY_Q15
                 : gain_q16((volume_step > MAX_STEP) ? MAX_STEP : volume_step);

   function automatic logic signed [15:0] scale(input logic signed [15:0] x,
                                               input logic [GAIN_W-1:0] k,
                                               input logic idle);
      logic signed [16:0] xs;
      logic [16:0]        mag;
      logic [33:0]        prod;
      logic [16:0]        shifted;
      xs      = {x[15], x};
      mag     = xs[16] ? 17'(-xs) : 17'(xs);
      prod    = 34'(mag) * 34'(k);
      shifted = idle ? prod[31:15] : prod[32:16];
      // fade-out snaps small magnitudes to silence
      if (idle && (shifted < SNAP_LIMIT)) begin
         shifted = '0;
      end
      return xs[16] ? 16'(-shifted) : shifted[15:0];
   endfunction

   assign held_left_in  = scale(entry_ctl.idle ? held_left_ff  : entry_left,  coef,
                                entry_ctl.idle);
   assign held_right_in = scale(entry_ctl.idle ? held_right_ff : entry_right, coef,
                                entry_ctl.idle);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         out_v_ff      <= 1'b0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
      end else begin
         if (advance) begin
            v1_ff    <= entry_valid;
            v2_ff    <= v1_ff;
            out_v_ff <= v2_ff;
         end
         if (pop) begin
            held_left_ff  <= held_left_in;
            held_right_ff <= held_right_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         neg_left_ff  <= entry_sum_left[SUM_W-1];
         neg_right_ff <= entry_sum_right[SUM_W-1];
         mag_left_ff  <= entry_sum_left[SUM_W-1]  ? SUM_W'(-entry_sum_left)
                                                   : SUM_W'(entry_sum_left);
         mag_right_ff <= entry_sum_right[SUM_W-1] ? SUM_W'(-entry_sum_right)
                                                   : SUM_W'(entry_sum_right);
         sv1_ff       <= entry_ctl.scope_valid;
      end
      if (advance && v1_ff) begin
         prod_left_ff   <= PROD_W'(mag_left_ff)  * PROD_W'(RECIP);
         prod_right_ff  <= PROD_W'(mag_right_ff) * PROD_W'(RECIP);
         neg_left2_ff   <= neg_left_ff;
         neg_right2_ff  <= neg_right_ff;
         sv2_ff         <= sv1_ff;
         held_left2_ff  <= held_left_ff;
         held_right2_ff <= held_right_ff;
      end
      if (advance && v2_ff) begin
         out_left_ff    <= held_left2_ff;
         out_right_ff   <= held_right2_ff;
         out_sv_ff      <= sv2_ff;
         scope_left_ff  <= neg_left2_ff  ? 16'(-quot_left)  : quot_left[15:0];
         scope_right_ff <= neg_right2_ff ? 16'(-quot_right) : quot_right[15:0];
      end
   end

   assign quot_left  = prod_left_ff[SHIFT+16:SHIFT];
   assign quot_right = prod_right_ff[SHIFT+16:SHIFT];

   assign rsp_valid       = out_v_ff;
   assign rsp_left_out    = out_left_ff;
   assign rsp_right_out   = out_right_ff;
   assign rsp_scope_valid = out_sv_ff;
   assign rsp_scope_left  = scope_left_ff;
   assign rsp_scope_right = scope_right_ff;

endmodule

`default_nettype wire

// ----- rtl/core/audio_volume_ramp_scope_path.sv -----
// An accepted req word passes the queue, then back-end stage 1, stage 2 and the
// output stage to rsp_valid; the queue adds up to 4 more words of slack under
// output stall. Throughput: one word per cycle while rsp_stall is low, set by the
// held-frame loop through the per-channel gain/decay multipliers in stage 1.
// Reset (synchronous): empties queue and pipeline, clears held frame and scope
// sums, volume_step -> 45, scope_enable -> 1.
`default_nettype none

module audio_volume_ramp_scope_path #(
   parameter int SCOPE_DECIMATION = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic signed [15:0]            req_left_in,
   input  wire logic signed [15:0]            req_right_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [15:0]                 rsp_left_out,
   output logic signed [15:0]                 rsp_right_out,
   output logic                               rsp_scope_valid,
   output logic signed [15:0]                 rsp_scope_left,
   output logic signed [15:0]                 rsp_scope_right,
   input  wire logic                          csr_we,
   input  wire avrsp_pkg::avrsp_csr_type      csr_index,
   input  wire logic [5:0]                    csr_wdata
);
   import avrsp_pkg::*;

   localparam int SUM_W = 17 + $clog2(SCOPE_DECIMATION);
   localparam int CTL_W = $bits(avrsp_ctl_type);
   localparam int ENT_W = CTL_W + 2 * SAMPLE_W + 2 * SUM_W;

   logic [VOL_W-1:0] volume_ff;
   logic             scope_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff   <= RESET_STEP;
         scope_en_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VOLUME_STEP: begin
               volume_ff <= (csr_wdata > MAX_STEP) ? MAX_STEP : csr_wdata;
            end
            CSR_SCOPE_ENABLE: begin
               scope_en_ff <= csr_wdata[0];
            end
            default: begin
               volume_ff <= volume_ff;
            end
         endcase
      end
   end

   logic                    push, pop, q_full, q_valid;
   avrsp_ctl_type           push_ctl, pop_ctl;
   logic signed [15:0]      push_left, push_right, pop_left, pop_right;
   logic signed [SUM_W-1:0] push_sum_left, push_sum_right, pop_sum_left, pop_sum_right;
   logic [ENT_W-1:0]        q_wdata, q_rdata;

   avrsp_front #(
      .DECIM (SCOPE_DECIMATION),
      .SUM_W (SUM_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_left_in    (req_left_in),
      .req_right_in   (req_right_in),
      .scope_enable   (scope_en_ff),
      .queue_full     (q_full),
      .push           (push),
      .push_ctl       (push_ctl),
      .push_left      (push_left),
      .push_right     (push_right),
      .push_sum_left  (push_sum_left),
      .push_sum_right (push_sum_right)
   );

   assign q_wdata = {push_ctl, push_left, push_right, push_sum_left, push_sum_right};
   assign {pop_ctl, pop_left, pop_right, pop_sum_left, pop_sum_right} = q_rdata;

   avrsp_queue #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (pop),
      .rdata     (q_rdata),
      .not_empty (q_valid)
   );

   avrsp_back #(
      .DECIM (SCOPE_DECIMATION),
      .SUM_W (SUM_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .entry_valid     (q_valid),
      .pop             (pop),
      .entry_ctl       (pop_ctl),
      .entry_left      (pop_left),
      .entry_right     (pop_right),
      .entry_sum_left  (pop_sum_left),
      .entry_sum_right (pop_sum_right),
      .volume_step     (volume_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out),
      .rsp_scope_valid (rsp_scope_valid),
      .rsp_scope_left  (rsp_scope_left),
      .rsp_scope_right (rsp_scope_right)
   );

endmodule

`default_nettype wire

// ----- rtl/core/avrsp_checker.sv -----
// Port-level checks for the volume path, bound onto the top level.
// Depends on audio_volume_ramp_scope_path_assert.svh.
`default_nettype none

`include "audio_volume_ramp_scope_path_assert.svh"

module avrsp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_left_out,
   input wire logic signed [15:0] rsp_right_out,
   input wire logic               rsp_scope_valid,
   input wire logic signed [15:0] rsp_scope_left,
   input wire logic signed [15:0] rsp_scope_right
);

   // a stalled result word holds
   `AVRSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out) && $stable(rsp_scope_valid) && $stable(rsp_scope_left) && $stable(rsp_scope_right))

   // scope fields are zero outside a decimation boundary
   `AVRSP_ASSERT_IMP(a_scope_zero, clock, reset, rsp_valid && !rsp_scope_valid, rsp_scope_left == 16'sd0 && rsp_scope_right == 16'sd0)

   // reset empties the pipeline and the queue
   `AVRSP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

   // a word needs a free queue slot: no stall while nothing downstream is held up
   `AVRSP_ASSERT_NEXT(a_no_idle_stall, clock, reset, !req_valid && !rsp_valid && !req_stall, !req_stall)

endmodule

bind audio_volume_ramp_scope_path avrsp_checker u_avrsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_left_out    (rsp_left_out),
   .rsp_right_out   (rsp_right_out),
   .rsp_scope_valid (rsp_scope_valid),
   .rsp_scope_left  (rsp_scope_left),
   .rsp_scope_right (rsp_scope_right)
);

`default_nettype wire
